@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/irc_tok_pkg.sv @@
// ---------------------------------------------------------------------------
// irc_tok_pkg
// Types and constants shared by the IRC tokenizer controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package irc_tok_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int PC_W     = 5;

    typedef enum logic [2:0] {
        MODE_LINE_START = 3'd0,
        MODE_PREFIX     = 3'd1,
        MODE_CMD_GAP    = 3'd2,
        MODE_COMMAND    = 3'd3,
        MODE_PARAM_LEAD = 3'd4,
        MODE_MIDDLE     = 3'd5,
        MODE_GAP        = 3'd6,
        MODE_TRAILING   = 3'd7
    } parse_mode_t;

    typedef enum logic [2:0] {
        ROLE_PREFIX   = 3'd0,
        ROLE_COMMAND  = 3'd1,
        ROLE_MIDDLE   = 3'd2,
        ROLE_TRAILING = 3'd3,
        ROLE_LINE_END = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        WS_SPACE = 2'd0,
        WS_CR    = 2'd1,
        WS_LF    = 2'd2
    } ws_code_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_PROC  = 3'd2,
        ST_FINAL = 3'd3,
        ST_DONE  = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0]      out_byte;
        role_t           role;
        logic [3:0]      param_index;
        logic            field_start;
        logic [PC_W-1:0] param_count;
        logic            overflow;
        logic            last;
    } result_t;

    typedef struct packed {
        logic hold_ws;     // store an incoming whitespace byte
        logic start;       // latch a byte or line end, arm the flush
        logic rd;          // read the held entry at the flush index
        logic proc_held;   // parse the held entry just read
        logic proc_final;  // parse the latched byte or close the line
        logic push_last;   // move the pending result out, marked last
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_hold;     // offered byte goes to the hold store
        logic has_held;    // flush length of the offered item is nonzero
        logic last_held;   // current flush entry is the final one
        logic out_free;    // output register can take a result
        logic pend_valid;  // a result is waiting in the pending slot
    } ctrl_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/irc_message_tokenizer_unit.sv @@
// ---------------------------------------------------------------------------
// irc_message_tokenizer_unit
// Byte-stream IRC line tokenizer with role tags, parameter index and count.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side takes one line character per transfer in s_tdata, or a line
//   end when s_tuser is high (s_tdata ignored then). Master side gives one
//   tagged result per transfer; m_tlast marks the final result of an input.
//   Space, CR and LF go to the hold store without results. Any other
//   byte first replays the held whitespace through the parser, then
//   parses itself. The replay loop reads each held entry with a
//   registered read, then parses it. A line end replays only the held
//   bytes that survive stripping, then gives the line-end result
//   carrying the parameter count.
//   Results pass through a pending slot and the output register, so the
//   unit keeps parsing while a result waits; when m_tready stays low the
//   sequencer holds at the next result it must place, and input waits.
//   Reset returns the parser to line start with an empty hold store; no
//   clearing pass is needed and the unit is ready in the first cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module irc_message_tokenizer_unit #(
    parameter int MAX_PARAMETERS = 15,
    parameter int HOLD_DEPTH     = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] line_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [11:8] param_index,
                                   // [12] field_start, [17:13] param_count,
                                   // [18] overflow, [23:19] zero
    output logic [2:0]  m_tuser,   // [2:0] role
    output logic        m_tlast    // last result of the input transfer
);
    import irc_tok_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    result_t    out_res;

    // sequencer: item acceptance, replay loop, item close
    irc_tok_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // parse state, hold store and result registers
    irc_tok_dp #(
        .MAX_PARAMETERS (MAX_PARAMETERS),
        .HOLD_DEPTH     (HOLD_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_tdata),
        .in_line_end (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_res     (out_res)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {5'd0, out_res.overflow, out_res.param_count, out_res.field_start,
                      out_res.param_index, out_res.out_byte};
    assign m_tuser = out_res.role;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

@@ rtl/core/irc_tok_ctrl.sv @@
// ---------------------------------------------------------------------------
// irc_tok_ctrl
// Sequencer: takes items, walks the held whitespace, closes each item.
// ---------------------------------------------------------------------------
`default_nettype none

module irc_tok_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  irc_tok_pkg::ctrl_stat_t stat,
    output irc_tok_pkg::ctrl_cmd_t  cmd
);
    import irc_tok_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !stat.in_hold)
                begin
                    state_next = stat.has_held ? ST_READ : ST_FINAL;
                end
            end
            ST_READ:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_held ? ST_FINAL : ST_READ;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.hold_ws = stat.in_hold;
                    cmd.start   = !stat.in_hold;
                end
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_PROC:
            begin
                cmd.proc_held = stat.out_free;
            end
            ST_FINAL:
            begin
                cmd.proc_final = stat.out_free;
            end
            ST_DONE:
            begin
                cmd.push_last = stat.pend_valid && stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/irc_tok_dp.sv @@
// ---------------------------------------------------------------------------
// irc_tok_dp
// Datapath: hold store, parse state, pending and output result registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module irc_tok_dp #(
    parameter int MAX_PARAMETERS = 15,
    parameter int HOLD_DEPTH     = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire [7:0]               in_byte,
    input  wire                     in_line_end,
    input  irc_tok_pkg::ctrl_cmd_t  cmd,
    output irc_tok_pkg::ctrl_stat_t stat,
    input  wire                     m_tready,
    output logic                    m_tvalid,
    output irc_tok_pkg::result_t    out_res
);
    import irc_tok_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);

    // hold store, no reset: only entries below the fill count are read
    ws_code_t hold_mem [HOLD_DEPTH];

    parse_mode_t     mode_reg,   mode_next;
    logic [PC_W-1:0] pc_reg,     pc_next;
    logic            fopen_reg,  fopen_next;
    logic            ovf_reg,    ovf_next;
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [CNT_W-1:0] lmark_reg,  lmark_next;   // one past the last CR/LF
    logic [CNT_W-1:0] nstrip_reg, nstrip_next;  // flush length at line end
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] limit_reg,  limit_next;
    logic [7:0]       byte_q_reg;
    logic             lend_q_reg;
    ws_code_t         rdata_reg;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg,       pend_next;
    logic             out_valid_reg,  out_valid_next;
    result_t          out_reg,        out_next;

    logic        in_ws;
    ws_code_t    in_code;
    logic        hold_ok;
    logic [7:0]  p_char;
    logic        do_proc;
    logic        p_sp;
    logic        p_col;
    logic        p_emit;
    logic        p_enter;
    role_t       p_role;
    parse_mode_t p_mode;
    logic        p_pc_inc;
    logic        p_ovf;
    logic        line_close;
    logic        emit_now;
    result_t     new_res;
    logic        out_free;

    assign in_ws   = (in_byte == CH_SPACE) || (in_byte == CH_CR) || (in_byte == CH_LF);
    assign in_code = (in_byte == CH_SPACE) ? WS_SPACE : ((in_byte == CH_CR) ? WS_CR : WS_LF);
    assign hold_ok = held_count_reg < CNT_W'(HOLD_DEPTH);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        stat.in_hold    = !in_line_end && in_ws;
        stat.has_held   = in_line_end ? (nstrip_reg != '0) : (held_count_reg != '0);
        stat.last_held  = CNT_W'(idx_reg + 1'b1) == limit_reg;
        stat.out_free   = out_free;
        stat.pend_valid = pend_valid_reg;
    end

    // character under parse: a held whitespace entry or the latched byte
    always_comb
    begin
        case (rdata_reg)
            WS_CR:   p_char = cmd.proc_held ? CH_CR : byte_q_reg;
            WS_LF:   p_char = cmd.proc_held ? CH_LF : byte_q_reg;
            default: p_char = cmd.proc_held ? CH_SPACE : byte_q_reg;
        endcase
    end

    assign do_proc    = cmd.proc_held || (cmd.proc_final && !lend_q_reg);
    assign line_close = cmd.proc_final && lend_q_reg;
    assign p_sp       = (p_char == CH_SPACE);
    assign p_col      = (p_char == CH_COLON);

    // one parse step
    always_comb
    begin
        p_emit   = 1'b0;
        p_enter  = 1'b0;
        p_role   = ROLE_PREFIX;
        p_mode   = mode_reg;
        p_pc_inc = 1'b0;
        p_ovf    = 1'b0;
        case (mode_reg)
            MODE_LINE_START:
            begin
                p_enter = 1'b1;
                if (p_col)
                begin
                    p_mode = MODE_PREFIX;
                end
                else if (p_sp)
                begin
                    p_mode = MODE_PARAM_LEAD;
                end
                else
                begin
                    p_mode = MODE_COMMAND;
                    p_emit = 1'b1;
                    p_role = ROLE_COMMAND;
                end
            end
            MODE_PREFIX:
            begin
                if (p_sp)
                begin
                    p_enter = 1'b1;
                    p_mode  = MODE_CMD_GAP;
                end
                else
                begin
                    p_emit = 1'b1;
                    p_role = ROLE_PREFIX;
                end
            end
            MODE_CMD_GAP:
            begin
                if (!p_sp)
                begin
                    p_enter = 1'b1;
                    p_mode  = MODE_COMMAND;
                    p_emit  = 1'b1;
                    p_role  = ROLE_COMMAND;
                end
            end
            MODE_COMMAND:
            begin
                if (p_sp)
                begin
                    p_enter = 1'b1;
                    p_mode  = MODE_PARAM_LEAD;
                end
                else
                begin
                    p_emit = 1'b1;
                    p_role = ROLE_COMMAND;
                end
            end
            MODE_PARAM_LEAD, MODE_GAP:
            begin
                if (!p_sp)
                begin
                    p_enter = 1'b1;
                    if (p_col)
                    begin
                        p_mode = MODE_TRAILING;
                    end
                    else
                    begin
                        p_mode = MODE_MIDDLE;
                        p_emit = 1'b1;
                        p_role = ROLE_MIDDLE;
                    end
                end
            end
            MODE_MIDDLE:
            begin
                if (p_sp)
                begin
                    p_enter = 1'b1;
                    p_mode  = MODE_GAP;
                    if (({1'b0, pc_reg} + 6'd1) < 6'(MAX_PARAMETERS))
                    begin
                        p_pc_inc = 1'b1;
                    end
                    else
                    begin
                        p_ovf = 1'b1;
                    end
                end
                else
                begin
                    p_emit = 1'b1;
                    p_role = ROLE_MIDDLE;
                end
            end
            default:
            begin
                p_emit = 1'b1;
                p_role = ROLE_TRAILING;
            end
        endcase
    end

    assign emit_now = (do_proc && p_emit) || line_close;

    always_comb
    begin
        new_res.last     = 1'b0;
        new_res.overflow = ovf_reg;
        if (line_close)
        begin
            new_res.out_byte    = 8'd0;
            new_res.role        = ROLE_LINE_END;
            new_res.param_index = pc_reg[3:0];
            new_res.field_start = 1'b0;
            new_res.param_count = pc_reg + 1'b1;
        end
        else
        begin
            new_res.out_byte    = p_char;
            new_res.role        = p_role;
            new_res.param_index = ((p_role == ROLE_MIDDLE) || (p_role == ROLE_TRAILING)) ?
                                  pc_reg[3:0] : 4'd0;
            new_res.field_start = p_enter || !fopen_reg;
            new_res.param_count = '0;
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        pc_next         = pc_reg;
        fopen_next      = fopen_reg;
        ovf_next        = ovf_reg;
        held_count_next = held_count_reg;
        lmark_next      = lmark_reg;
        nstrip_next     = nstrip_reg;
        idx_next        = idx_reg;
        limit_next      = limit_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;

        if (cmd.hold_ws)
        begin
            if (hold_ok)
            begin
                held_count_next = CNT_W'(held_count_reg + 1'b1);
                if (in_code == WS_SPACE)
                begin
                    nstrip_next = lmark_reg;
                end
                else
                begin
                    if (lmark_reg != held_count_reg)
                    begin
                        nstrip_next = lmark_reg;
                    end
                    lmark_next = CNT_W'(held_count_reg + 1'b1);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.start)
        begin
            limit_next      = in_line_end ? nstrip_reg : held_count_reg;
            idx_next        = '0;
            held_count_next = '0;
            lmark_next      = '0;
            nstrip_next     = '0;
        end

        if (cmd.proc_held)
        begin
            idx_next = CNT_W'(idx_reg + 1'b1);
        end

        if (do_proc)
        begin
            mode_next = p_mode;
            if (p_pc_inc)
            begin
                pc_next = pc_reg + 1'b1;
            end
            if (p_ovf)
            begin
                ovf_next = 1'b1;
            end
            if (p_emit)
            begin
                fopen_next = 1'b1;
            end
            else if (p_enter)
            begin
                fopen_next = 1'b0;
            end
        end

        // hold one result back so the final one of an item can be marked
        if (emit_now)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
        end

        if (cmd.push_last)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (line_close)
        begin
            mode_next  = MODE_LINE_START;
            pc_next    = '0;
            fopen_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LINE_START;
            pc_reg         <= '0;
            fopen_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            held_count_reg <= '0;
            lmark_reg      <= '0;
            nstrip_reg     <= '0;
            idx_reg        <= '0;
            limit_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pc_reg         <= pc_next;
            fopen_reg      <= fopen_next;
            ovf_reg        <= ovf_next;
            held_count_reg <= held_count_next;
            lmark_reg      <= lmark_next;
            nstrip_reg     <= nstrip_next;
            idx_reg        <= idx_next;
            limit_reg      <= limit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (cmd.start)
        begin
            byte_q_reg <= in_byte;
            lend_q_reg <= in_line_end;
        end
        if (cmd.hold_ws && hold_ok)
        begin
            hold_mem[held_count_reg[IDX_W-1:0]] <= in_code;
        end
        if (cmd.rd)
        begin
            rdata_reg <= hold_mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_res  = out_reg;

    `ASSERT_ALWAYS(a_hold_bound, clk, rst_n, held_count_reg <= CNT_W'(HOLD_DEPTH), "hold count past depth")
    `ASSERT_ALWAYS(a_strip_order, clk, rst_n, (nstrip_reg <= lmark_reg) && (lmark_reg <= held_count_reg), "strip marks out of order")
    `ASSERT_IMPLIES(a_push_has_pend, clk, rst_n, cmd.push_last || emit_now, out_free, "result moved while output stalled")
    `ASSERT_NEXT(a_line_clears, clk, rst_n, line_close, (mode_reg == MODE_LINE_START) && (pc_reg == '0) && !ovf_reg && pend_valid_reg, "line state not cleared")

endmodule

`default_nettype wire

@@ dv/tb_irc_message_tokenizer_unit.sv @@
// ---------------------------------------------------------------------------
// tb_irc_message_tokenizer_unit
// Self-checking bench for the IRC line tokenizer. A queue of line bytes and
// line ends, directed first and then random whole lines with noise mixed in,
// feeds a bursty stream driver. Every accepted input runs through a local
// tokenizer model that queues the tagged tokens it should produce. A monitor
// takes results under a rotating ready pattern and checks each one field by
// field against the oldest queued token.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_irc_message_tokenizer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import irc_tok_pkg::*;

    localparam int PARAM_LIMIT    = 15;
    localparam int HOLD_SLOTS     = 32;
    localparam int DIRECTED_ITEMS = 26;
    localparam int RANDOM_ITEMS   = 344;
    // A byte after a full hold store replays every held entry; leave margin.
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 30;

    // One slave-side transfer: a line character or a line end.
    typedef struct packed {
        logic [7:0] chr;
        logic       eol;
    } line_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] line_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] out_byte, [11:8] param_index,
                                     // [12] field_start, [17:13] param_count,
                                     // [18] overflow, [23:19] zero
    logic [2:0]  m_tuser;            // [2:0] role
    logic        m_tlast;

    line_item_t  line_q[$];          // items still to be offered
    result_t     token_q[$];         // tokens expected from the block, oldest first
    result_t     step_tokens[$];     // tokens of the item being modeled

    // Tokenizer model state
    parse_mode_t scan_mode;
    logic [4:0]  prm_cnt;
    logic        fld_open;
    ws_code_t    ws_store [HOLD_SLOTS];
    int          ws_cnt;
    logic        ovf_seen;

    int          err_cnt     = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          idle_cycles = 0;
    logic [15:0] ready_pat   = 16'hFFFF;
    logic [5:0]  pat_age     = 6'd0;

    irc_message_tokenizer_unit #(
        .MAX_PARAMETERS (PARAM_LIMIT),
        .HOLD_DEPTH     (HOLD_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Tokenizer model
    // -----------------------------------------------------------------------

    // Return every piece of line state to its power-up value.
    function automatic void clear_line_state();
        scan_mode = MODE_LINE_START;
        prm_cnt   = '0;
        fld_open  = 1'b0;
        ws_cnt    = 0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic void enter_mode(input parse_mode_t m);
        scan_mode = m;
        fld_open  = 1'b0;
    endfunction

    // Tag one kept byte; prefix and command bytes carry index zero.
    function automatic void emit_token(input logic [7:0] b, input role_t r);
        result_t t;
        t             = '0;
        t.out_byte    = b;
        t.role        = r;
        t.param_index = (r >= ROLE_MIDDLE) ? prm_cnt[3:0] : 4'd0;
        t.field_start = !fld_open;
        t.overflow    = ovf_seen;
        fld_open      = 1'b1;
        step_tokens.push_back(t);
    endfunction

    // Advance the line scanner by one character.
    function automatic void scan_char(input logic [7:0] c);
        logic sp;
        sp = (c == CH_SPACE);
        case (scan_mode)
            MODE_LINE_START:
                if (c == CH_COLON)
                    enter_mode(MODE_PREFIX);
                else if (sp)
                    enter_mode(MODE_PARAM_LEAD);   // empty command
                else
                begin
                    enter_mode(MODE_COMMAND);
                    emit_token(c, ROLE_COMMAND);
                end
            MODE_PREFIX:
                if (sp)
                    enter_mode(MODE_CMD_GAP);
                else
                    emit_token(c, ROLE_PREFIX);
            MODE_CMD_GAP:
                if (!sp)
                begin
                    enter_mode(MODE_COMMAND);
                    emit_token(c, ROLE_COMMAND);
                end
            MODE_COMMAND:
                if (sp)
                    enter_mode(MODE_PARAM_LEAD);
                else
                    emit_token(c, ROLE_COMMAND);
            MODE_PARAM_LEAD, MODE_GAP:
                if (!sp)
                begin
                    if (c == CH_COLON)
                        enter_mode(MODE_TRAILING);
                    else
                    begin
                        enter_mode(MODE_MIDDLE);
                        emit_token(c, ROLE_MIDDLE);
                    end
                end
            MODE_MIDDLE:
                if (sp)
                begin
                    // saturate the index, flag the extra parameters
                    if (int'(prm_cnt) + 1 < PARAM_LIMIT)
                        prm_cnt = prm_cnt + 5'd1;
                    else
                        ovf_seen = 1'b1;
                    enter_mode(MODE_GAP);
                end
                else
                    emit_token(c, ROLE_MIDDLE);
            default:
                emit_token(c, ROLE_TRAILING);
        endcase
    endfunction

    function automatic logic [7:0] ws_to_char(input ws_code_t w);
        case (w)
            WS_CR:   return CH_CR;
            WS_LF:   return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    // Replay the first n held whitespace bytes and empty the store.
    function automatic void replay_held(input int n);
        for (int i = 0; i < n; i++)
            scan_char(ws_to_char(ws_store[i]));
        ws_cnt = 0;
    endfunction

    // Model one accepted transfer and queue the tokens it causes.
    function automatic void tokenize_item(input logic [7:0] chr, input logic eol);
        result_t t;
        int      n;
        step_tokens.delete();
        if (eol)
        begin
            // strip trailing CR/LF first, then the spaces before them
            n = ws_cnt;
            while (n > 0 && ws_store[n-1] != WS_SPACE)
                n--;
            while (n > 0 && ws_store[n-1] == WS_SPACE)
                n--;
            replay_held(n);
            t             = '0;
            t.role        = ROLE_LINE_END;
            t.param_index = prm_cnt[3:0];
            t.param_count = prm_cnt + 5'd1;
            t.overflow    = ovf_seen;
            t.last        = 1'b1;
            step_tokens.push_back(t);
            clear_line_state();
        end
        else if (chr == CH_SPACE || chr == CH_CR || chr == CH_LF)
        begin
            if (ws_cnt < HOLD_SLOTS)
            begin
                ws_store[ws_cnt] = (chr == CH_SPACE) ? WS_SPACE :
                                   (chr == CH_CR)    ? WS_CR : WS_LF;
                ws_cnt++;
            end
            else
                ovf_seen = 1'b1;               // hold store full: drop the byte
        end
        else
        begin
            replay_held(ws_cnt);
            scan_char(chr);
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size()-1].last = 1'b1;
        end
        foreach (step_tokens[i])
            token_q.push_back(step_tokens[i]);
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus building
    // -----------------------------------------------------------------------

    function automatic void push_byte(input logic [7:0] b);
        line_item_t it;
        it.chr = b;
        it.eol = 1'b0;
        line_q.push_back(it);
    endfunction

    // Line end; the data byte rides along and must be ignored.
    function automatic void push_eol(input logic [7:0] b);
        line_item_t it;
        it.chr = b;
        it.eol = 1'b1;
        line_q.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] name_byte();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] wild_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly printable, now and then any byte (CR/LF and spaces included).
    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 7) == 0) ? wild_byte() : name_byte();
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Separator run; now and then long enough to overrun the hold store.
    function automatic void push_gap();
        int n;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(HOLD_SLOTS + 1, HOLD_SLOTS + 4)
                                         : $urandom_range(1, 3);
        repeat (n) push_byte(CH_SPACE);
    endfunction

    // One random line: mostly well formed, sometimes raw noise.
    function automatic void build_line();
        int nprm;
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) push_byte(wild_byte());
            push_eol(wild_byte());
            return;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            push_byte(CH_COLON);
            repeat ($urandom_range(1, 6)) push_byte(name_byte());
            push_gap();
        end
        if ($urandom_range(0, 7) == 0)
            push_byte(CH_SPACE);
        else
            repeat ($urandom_range(1, 6)) push_byte(name_byte());
        // occasionally run past the parameter limit
        nprm = ($urandom_range(0, 5) == 0) ? $urandom_range(PARAM_LIMIT - 1, PARAM_LIMIT + 3)
                                           : $urandom_range(0, 4);
        repeat (nprm)
        begin
            push_gap();
            push_byte(name_byte());
            repeat ($urandom_range(0, 4)) push_byte(text_byte());
        end
        if ($urandom_range(0, 1) == 0)
        begin
            push_gap();
            push_byte(CH_COLON);
            repeat ($urandom_range(0, 8))
                push_byte(($urandom_range(0, 3) == 0) ? CH_SPACE : text_byte());
        end
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(HOLD_SLOTS - 2, HOLD_SLOTS + 4)
                                         : $urandom_range(0, 4);
        repeat (n) push_byte(ws_byte());
        push_eol(wild_byte());
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (err_cnt < PRINT_CAP)
            $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    // -----------------------------------------------------------------------
    // Driver: offer queued items in bursts with random gaps between them.
    // Model each item at the edge where its transfer completes.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        line_item_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                tokenize_item(s_tdata, s_tuser);
            // advance only when the bus is empty or its item just moved
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || line_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    nxt = line_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.chr;
                    s_tuser  <= nxt.eol;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // new burst; some run back to back with no gap at all
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 48)
                                                               : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: rotate a 16-bit ready pattern, reload it when the 6-bit age counter wraps.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (pat_age == 6'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = 16'hFFFF;                              // no stalls
                    1:       ready_pat = 16'($urandom) | 16'h0001;
                    2:       ready_pat = 16'($urandom & $urandom) | 16'h0001;  // mostly stalled
                    default: ready_pat = 16'($urandom | $urandom);
                endcase
            end
            pat_age   = pat_age + 6'd1;
            m_tready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expected token.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (token_q.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%0d tlast=%0b",
                                          m_tdata, m_tuser, m_tlast));
            else
            begin
                want = token_q.pop_front();
                if (m_tdata[7:0] !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              m_tdata[7:0], want.out_byte));
                if (m_tuser !== want.role)
                    report_mismatch($sformatf("role %0d, expected %0d", m_tuser, want.role));
                if (m_tdata[11:8] !== want.param_index)
                    report_mismatch($sformatf("param_index %0d, expected %0d",
                                              m_tdata[11:8], want.param_index));
                if (m_tdata[12] !== want.field_start)
                    report_mismatch($sformatf("field_start %0b, expected %0b",
                                              m_tdata[12], want.field_start));
                if (m_tdata[17:13] !== want.param_count)
                    report_mismatch($sformatf("param_count %0d, expected %0d",
                                              m_tdata[17:13], want.param_count));
                if (m_tdata[18] !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              m_tdata[18], want.overflow));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either side for too long.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("irc_message_tokenizer_unit verification failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence: build all stimulus, release reset, wait for the drain.
    // -----------------------------------------------------------------------
    initial
    begin
        clear_line_state();

        // Prefix, a command that starts with a colon, a colon inside a
        // middle parameter, trailing text with a kept space, and trailing
        // space + CR + LF stripped at line end.
        push_text(":a :b c:d :e f ");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_eol(wild_byte());
        // Empty command from a leading space, extreme byte values, and a CR
        // in the middle of a parameter; line end carrying an all-ones byte.
        push_byte(CH_SPACE);
        push_byte(8'h00);
        push_byte(CH_SPACE);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte("x");
        push_eol(8'hFF);
        // Empty line
        push_eol(8'h00);

        while (line_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
            build_line();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // hold until every item is taken and every token has come back
        while (line_q.size() != 0 || s_tvalid || token_q.size() != 0)
            @(posedge clk);
        // let any stray late result surface
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("irc_message_tokenizer_unit verification clean");
        else
            $display("irc_message_tokenizer_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
